// ----- rtl/sws_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sws_pkg
// Shared constants and helpers for the stack with bottom increment.
// ----------------------------------------------------------------------------
package sws_pkg;

	// Default configuration handed to the top level
	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_VALUE_WIDTH = 32;

	// Fixed field widths
	localparam int FIELD_WIDTH  = 32;
	localparam int CMD_WIDTH    = 2;
	localparam int COUNT_WIDTH  = 7;
	localparam int STATUS_WIDTH = 2;
	localparam int EXT_WIDTH    = 64;

	// Command codes
	localparam logic [CMD_WIDTH-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_INC  = 2'd2;

	// Status codes
	localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_PUSH_FULL = 2'd2;

	// Sign-extend a 32-bit field to the widest supported value width
	function automatic logic [EXT_WIDTH-1:0] sext_field(input logic [FIELD_WIDTH-1:0] f);
		return {{(EXT_WIDTH-FIELD_WIDTH){f[FIELD_WIDTH-1]}}, f};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/sws_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sws_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sws_ram #(
	parameter int DEPTH = sws_pkg::DEF_STACK_DEPTH,
	parameter int WIDTH = sws_pkg::DEF_VALUE_WIDTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sws_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sws_ctrl
// Command sequencer, fill counter, shared adder and result register.
// ----------------------------------------------------------------------------
module sws_ctrl #(
	parameter int STACK_DEPTH = sws_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = sws_pkg::DEF_VALUE_WIDTH,
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command side
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [sws_pkg::CMD_WIDTH-1:0]       command,
	input  wire logic signed [sws_pkg::FIELD_WIDTH-1:0] push_value,
	input  wire logic [sws_pkg::COUNT_WIDTH-1:0]     bottom_count,
	input  wire logic signed [sws_pkg::FIELD_WIDTH-1:0] add_amount,
	// result side
	output logic                                     done,
	output logic signed [sws_pkg::FIELD_WIDTH-1:0]   top_value,
	output logic                                     is_empty,
	output logic [sws_pkg::STATUS_WIDTH-1:0]         status,
	// entry store
	output logic                                     ram_we,
	output logic [AW-1:0]                            ram_waddr,
	output logic [VALUE_WIDTH-1:0]                   ram_wdata,
	output logic                                     ram_re,
	output logic [AW-1:0]                            ram_raddr,
	input  wire logic [VALUE_WIDTH-1:0]              ram_rdata
);

	localparam int NW = (CW > sws_pkg::COUNT_WIDTH) ? CW : sws_pkg::COUNT_WIDTH;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_INC  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]                        state_q;
	logic [sws_pkg::CMD_WIDTH-1:0]     cmd_q;
	logic [VALUE_WIDTH-1:0]            val_q;
	logic [VALUE_WIDTH-1:0]            amt_q;
	logic [CW-1:0]                     n_q;
	logic [CW-1:0]                     fill_q;
	logic [CW-1:0]                     rd_idx_q;
	logic                              pend_q;
	logic [AW-1:0]                     pidx_q;
	logic [sws_pkg::STATUS_WIDTH-1:0]  status_q;
	logic                              done_q;
	logic [sws_pkg::FIELD_WIDTH-1:0]   top_q;
	logic                              empty_q;

	logic                              accept;
	logic                              full;
	logic                              rd_more;
	logic [CW-1:0]                     top_idx;
	logic [NW-1:0]                     bc_ext;
	logic [NW-1:0]                     fill_ext;
	logic [CW-1:0]                     n_clamp;
	logic [sws_pkg::EXT_WIDTH-1:0]     push_ext;
	logic [sws_pkg::EXT_WIDTH-1:0]     amt_ext;
	logic [sws_pkg::EXT_WIDTH-1:0]     rd_ext;
	logic [VALUE_WIDTH-1:0]            sum;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign full     = (fill_q == CW'(STACK_DEPTH));
	assign rd_more  = (rd_idx_q < n_q);
	assign top_idx  = fill_q - 1'b1;

	// Count clamp against the fill level
	assign bc_ext   = NW'(bottom_count);
	assign fill_ext = NW'(fill_q);
	assign n_clamp  = (bc_ext > fill_ext) ? fill_q : CW'(bc_ext);

	// Field conversion to the stored width
	assign push_ext = sws_pkg::sext_field(push_value);
	assign amt_ext  = sws_pkg::sext_field(add_amount);
	assign rd_ext   = sws_pkg::EXT_WIDTH'(ram_rdata);

	// Shared adder, wraps at the value width
	assign sum = ram_rdata + amt_q;

	// Entry store access
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fill_q[AW-1:0];
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = rd_idx_q[AW-1:0];
		case (state_q)
			S_EXEC: begin
				if (cmd_q == sws_pkg::CMD_PUSH && !full) begin
					ram_we = 1'b1;
				end
			end
			S_INC: begin
				ram_re    = rd_more;
				ram_we    = pend_q;
				ram_waddr = pidx_q;
				ram_wdata = sum;
			end
			S_RD: begin
				ram_re    = (fill_q != '0);
				ram_raddr = top_idx[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			done_q   <= 1'b0;
			pend_q   <= 1'b0;
			status_q <= sws_pkg::ST_OK;
			empty_q  <= 1'b1;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= sws_pkg::ST_OK;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RD;
					case (cmd_q)
						sws_pkg::CMD_PUSH: begin
							if (full) begin
								status_q <= sws_pkg::ST_PUSH_FULL;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
						end
						sws_pkg::CMD_POP: begin
							if (fill_q == '0) begin
								status_q <= sws_pkg::ST_POP_EMPTY;
							end else begin
								fill_q <= fill_q - 1'b1;
							end
						end
						sws_pkg::CMD_INC: begin
							pend_q  <= 1'b0;
							state_q <= S_INC;
						end
						default: begin
						end
					endcase
				end
				S_INC: begin
					// read one entry per cycle, write back the previous one
					pend_q <= rd_more;
					if (!rd_more && !pend_q) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (fill_q == '0) begin
						done_q  <= 1'b1;
						empty_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					done_q  <= 1'b1;
					empty_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			val_q <= push_ext[VALUE_WIDTH-1:0];
			amt_q <= amt_ext[VALUE_WIDTH-1:0];
			n_q   <= n_clamp;
		end
		if (state_q == S_EXEC) begin
			rd_idx_q <= '0;
		end else if (state_q == S_INC && rd_more) begin
			rd_idx_q <= rd_idx_q + 1'b1;
			pidx_q   <= rd_idx_q[AW-1:0];
		end
		if (state_q == S_RD) begin
			top_q <= '0;
		end else if (state_q == S_OUT) begin
			top_q <= rd_ext[sws_pkg::FIELD_WIDTH-1:0];
		end
	end

	assign done      = done_q;
	assign top_value = top_q;
	assign is_empty  = empty_q;
	assign status    = status_q;

endmodule
`default_nettype wire

// ----- rtl/stack_with_bottom_increment_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stack_with_bottom_increment_top
// Bounded stack with push, pop and add-to-bottom-entries commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. busy then stays high
// until the cycle in which the result is shown, so the next command can be
// taken at the same edge that takes the result. Every command yields exactly
// one result, held on top_value, is_empty and status for the single cycle in
// which done is high. The receiver cannot stall, so it must capture the result
// then. Push, pop and unused codes pass through an execute state and a read of
// the top entry, then an output state when the stack is left non-empty; when
// it is left empty, done is raised from the read state. An increment of n bottom
// entries (n clamped to the fill level, 64 at most for a full 64-entry stack)
// first reads and writes back those n entries, then follows the same read and
// output steps. One adder, one read port and one write port of the entry
// store are shared by all entries, so one entry is updated per cycle. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module stack_with_bottom_increment_top #(
	parameter int STACK_DEPTH = sws_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = sws_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [sws_pkg::CMD_WIDTH-1:0]          command,
	input  wire logic signed [sws_pkg::FIELD_WIDTH-1:0] push_value,
	input  wire logic [sws_pkg::COUNT_WIDTH-1:0]        bottom_count,
	input  wire logic signed [sws_pkg::FIELD_WIDTH-1:0] add_amount,
	output logic                                        done,
	output logic signed [sws_pkg::FIELD_WIDTH-1:0]      top_value,
	output logic                                        is_empty,
	output logic [sws_pkg::STATUS_WIDTH-1:0]            status
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	// Sequencer and shared adder
	sws_ctrl #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.push_value   (push_value),
		.bottom_count (bottom_count),
		.add_amount   (add_amount),
		.done         (done),
		.top_value    (top_value),
		.is_empty     (is_empty),
		.status       (status),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	// Entry store
	sws_ram #(
		.DEPTH(STACK_DEPTH),
		.WIDTH(VALUE_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire
